// ===== rtl/mpts_pkg.sv =====
// ----------------------------------------------------------------------------
// mpts_pkg
// Shared types, codes and defaults of the multi-policy thread scheduler.
// ----------------------------------------------------------------------------
package mpts_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TOP_LEVEL_DEF   = 2;
    localparam int MAX_PRIO_DEF    = 20;

    // actions
    localparam logic [2:0] ACT_MAKE_READY = 3'd0;
    localparam logic [2:0] ACT_DISPATCH   = 3'd1;
    localparam logic [2:0] ACT_TICK       = 3'd2;
    localparam logic [2:0] ACT_PREEMPT    = 3'd3;
    localparam logic [2:0] ACT_SUSPEND    = 3'd4;
    localparam logic [2:0] ACT_RESUME     = 3'd5;

    // policies
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_RR   = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;
    localparam logic [1:0] POL_MLFQ = 2'd3;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_RR_Q   = 2'd1;
    localparam logic [1:0] REG_TOP_Q  = 2'd2;
    localparam logic [1:0] REG_MID_Q  = 2'd3;

    // fixed queue numbers
    localparam int READY_Q    = 0;
    localparam int SUSP_Q     = 1;
    localparam int LEVEL_BASE = 2;

    typedef struct packed {
        logic [7:0] id;
        logic [4:0] prio;
        logic [7:0] quantum;
        logic [7:0] burst;
    } t_entry;

    typedef enum logic [1:0] {
        MODE_APPEND,
        MODE_PREPEND,
        MODE_SORTED
    } t_mode;

    typedef enum logic [4:0] {
        C_NOP,
        C_LOAD,
        C_SIMPLE,
        C_RD_K,
        C_RD_KM1,
        C_RD_KP1,
        C_INC_K,
        C_SET_POS,
        C_WR_K_DEC,
        C_WR_K_INC,
        C_WR_POS,
        C_APPEND,
        C_PREPEND,
        C_TAKE,
        C_RM_END,
        C_DISPATCH,
        C_FIN_EMPTY,
        C_FIN_FULL,
        C_PUSH
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        t_mode      mode;
        logic       full;
        logic       empty;
        logic       k_lt_cnt;
        logic       k_gt_pos;
        logic       k1_lt_cnt;
        logic       match_id;
        logic       prio_ge;
    } t_dp_status;

endpackage

// ===== rtl/mpts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpts_ctrl
// Sequencer: walks the queue operations of one request and hands results on.
// ----------------------------------------------------------------------------
module mpts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  mpts_pkg::t_dp_status i_st,
    output mpts_pkg::t_cmd     o_cmd
);
    import mpts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_DISP, S_SCAN, S_SCAN_W, S_SHIFT, S_SHIFT_W,
        S_FIND, S_FIND_W, S_RSHIFT, S_RSHIFT_W, S_MOVE, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = C_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd     = C_LOAD;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (i_st.action)
                    ACT_MAKE_READY: begin
                        if (i_st.full) begin
                            cmd     = C_FIN_FULL;
                            n_state = S_DONE;
                        end else if (i_st.mode == MODE_APPEND) begin
                            cmd     = C_APPEND;
                            n_state = S_DONE;
                        end else if (i_st.mode == MODE_PREPEND) begin
                            cmd     = C_PREPEND;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    ACT_DISPATCH: begin
                        if (i_st.empty) begin
                            cmd     = C_FIN_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            cmd     = C_RD_K;
                            n_state = S_DISP;
                        end
                    end
                    ACT_SUSPEND, ACT_RESUME: n_state = S_FIND;
                    default: begin
                        cmd     = C_SIMPLE;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DISP: begin
                cmd     = C_DISPATCH;
                n_state = S_DONE;
            end
            // sorted insert: find first entry of lower priority
            S_SCAN: begin
                if (i_st.k_lt_cnt) begin
                    cmd     = C_RD_K;
                    n_state = S_SCAN_W;
                end else begin
                    cmd     = C_SET_POS;
                    n_state = S_SHIFT;
                end
            end
            S_SCAN_W: begin
                if (i_st.prio_ge) begin
                    cmd     = C_INC_K;
                    n_state = S_SCAN;
                end else begin
                    cmd     = C_SET_POS;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_st.k_gt_pos) begin
                    cmd     = C_RD_KM1;
                    n_state = S_SHIFT_W;
                end else begin
                    cmd     = C_WR_POS;
                    n_state = S_DONE;
                end
            end
            S_SHIFT_W: begin
                cmd     = C_WR_K_DEC;
                n_state = S_SHIFT;
            end
            S_FIND: begin
                if (i_st.k_lt_cnt) begin
                    cmd     = C_RD_K;
                    n_state = S_FIND_W;
                end else begin
                    cmd     = C_FIN_EMPTY;
                    n_state = S_DONE;
                end
            end
            S_FIND_W: begin
                if (i_st.match_id) begin
                    cmd     = C_TAKE;
                    n_state = S_RSHIFT;
                end else begin
                    cmd     = C_INC_K;
                    n_state = S_FIND;
                end
            end
            // close the gap left by the removed entry
            S_RSHIFT: begin
                if (i_st.k1_lt_cnt) begin
                    cmd     = C_RD_KP1;
                    n_state = S_RSHIFT_W;
                end else begin
                    cmd     = C_RM_END;
                    n_state = S_MOVE;
                end
            end
            S_RSHIFT_W: begin
                cmd     = C_WR_K_INC;
                n_state = S_RSHIFT;
            end
            S_MOVE: begin
                cmd     = i_st.full ? C_FIN_FULL : C_APPEND;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    cmd     = C_PUSH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
        if (cmd == C_PUSH) begin
            n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

// ===== rtl/mpts_dp.sv =====
// ----------------------------------------------------------------------------
// mpts_dp
// Datapath: queue memory, head and count registers, running thread, config.
// ----------------------------------------------------------------------------
module mpts_dp #(
    parameter int QUEUE_DEPTH = mpts_pkg::QUEUE_DEPTH_DEF,
    parameter int TOP_LEVEL   = mpts_pkg::TOP_LEVEL_DEF,
    parameter int MAX_PRIO    = mpts_pkg::MAX_PRIO_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mpts_pkg::t_cmd       i_cmd,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic [2:0]           i_action,
    input  logic [7:0]           i_thread_id,
    input  logic [4:0]           i_priority_req,
    input  logic [7:0]           i_quantum_left,
    input  logic [7:0]           i_burst_time,
    input  logic                 i_cpu_idle,
    output mpts_pkg::t_dp_status o_st,
    output logic [1:0]           o_status,
    output logic [7:0]           o_out_thread_id,
    output logic [4:0]           o_out_priority,
    output logic [7:0]           o_out_quantum,
    output logic                 o_yield_now,
    output logic                 o_do_switch
);
    import mpts_pkg::*;

    localparam int NQ = TOP_LEVEL + 3;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int QW = $clog2(NQ);
    localparam int MW = $clog2(NQ * QUEUE_DEPTH);
    localparam int LW = $clog2(TOP_LEVEL + 1);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [MW-1:0] DEPTH_M = MW'(QUEUE_DEPTH);

    t_entry       r_mem [NQ * QUEUE_DEPTH];
    t_entry       r_rdata;
    logic [AW-1:0] r_head [NQ];
    logic [CW-1:0] r_cnt  [NQ];
    logic [QW-1:0] r_q, r_dst;
    logic [CW-1:0] r_k, r_pos;
    t_entry       r_ent;
    logic [2:0]   r_action;
    logic [4:0]   r_praw;
    logic         r_idle;
    t_mode        r_mode;
    logic [1:0]   r_status;
    logic         r_yield, r_sw;
    logic [7:0]   r_run_id, r_run_q;
    logic [4:0]   r_run_prio;
    logic [1:0]   r_policy;
    logic [7:0]   r_rr_q, r_top_q, r_mid_q;
    logic [1:0]   r_o_status;
    logic [7:0]   r_o_id, r_o_q;
    logic [4:0]   r_o_prio;
    logic         r_o_yield, r_o_sw;

    // request decode at accept
    logic [4:0]    psat;
    logic [LW-1:0] lvl;
    t_entry        ld_ent;
    logic [QW-1:0] ld_q, ld_dst, disp_q;
    t_mode         ld_mode;

    always_comb begin
        psat = (32'(i_priority_req) > MAX_PRIO) ? 5'(MAX_PRIO) : i_priority_req;
        lvl  = (32'(psat) > TOP_LEVEL) ? LW'(TOP_LEVEL) : LW'(psat);
        ld_ent.id      = i_thread_id;
        ld_ent.prio    = psat;
        ld_ent.quantum = i_quantum_left;
        ld_ent.burst   = i_burst_time;
        ld_q    = QW'(READY_Q);
        ld_dst  = QW'(SUSP_Q);
        ld_mode = MODE_APPEND;
        disp_q  = QW'(LEVEL_BASE);
        for (int l = 0; l <= TOP_LEVEL; l++) begin
            if (r_cnt[LEVEL_BASE + l] != '0) begin
                disp_q = QW'(LEVEL_BASE + l);
            end
        end
        case (i_action)
            ACT_MAKE_READY: begin
                case (r_policy)
                    POL_RR:   ld_ent.quantum = r_rr_q;
                    POL_PRIO: ld_mode = MODE_SORTED;
                    POL_MLFQ: begin
                        ld_ent.prio = 5'(lvl);
                        ld_q = QW'(LEVEL_BASE) + QW'(lvl);
                        if (i_quantum_left != 8'd0) begin
                            ld_mode = MODE_PREPEND;
                        end else if (32'(lvl) == TOP_LEVEL) begin
                            ld_ent.quantum = r_top_q;
                        end else if (lvl == '0) begin
                            ld_ent.quantum = i_burst_time;
                        end else begin
                            ld_ent.quantum = r_mid_q;
                        end
                    end
                    default: ld_mode = MODE_APPEND;
                endcase
            end
            ACT_DISPATCH: begin
                if (r_policy == POL_MLFQ) begin
                    ld_q = disp_q;
                end
            end
            ACT_RESUME: begin
                ld_q   = QW'(SUSP_Q);
                ld_dst = QW'(READY_Q);
            end
            default: ld_q = QW'(READY_Q);
        endcase
    end

    // slot and memory address of the current access
    logic [CW-1:0] off;
    logic [CW:0]   sum;
    logic [AW-1:0] slot, slot_prev, head_next;
    logic [MW-1:0] addr;
    logic          rd_en, wr_en;
    t_entry        wr_data;

    always_comb begin
        case (i_cmd)
            C_RD_KM1:         off = r_k - 1'b1;
            C_RD_KP1:         off = r_k + 1'b1;
            C_WR_POS:         off = r_pos;
            C_APPEND:         off = r_cnt[r_q];
            default:          off = r_k;
        endcase
        sum = (CW + 1)'(r_head[r_q]) + (CW + 1)'(off);
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        slot_prev = (r_head[r_q] == '0) ? LAST_SLOT : r_head[r_q] - 1'b1;
        head_next = (r_head[r_q] == LAST_SLOT) ? '0 : r_head[r_q] + 1'b1;
        slot = (i_cmd == C_PREPEND) ? slot_prev : sum[AW-1:0];
        addr = MW'(r_q) * DEPTH_M + MW'(slot);
        rd_en = (i_cmd == C_RD_K) || (i_cmd == C_RD_KM1) || (i_cmd == C_RD_KP1);
        wr_en = (i_cmd == C_WR_K_DEC) || (i_cmd == C_WR_K_INC) || (i_cmd == C_WR_POS)
             || (i_cmd == C_APPEND) || (i_cmd == C_PREPEND);
        wr_data = ((i_cmd == C_WR_K_DEC) || (i_cmd == C_WR_K_INC)) ? r_rdata : r_ent;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[addr];
        end
    end

    // tick and preempt check
    logic       active;
    logic [7:0] tq;
    always_comb begin
        active = (r_policy == POL_RR) || (r_policy == POL_MLFQ && r_run_prio != 5'd0);
        tq = (r_run_q != 8'd0) ? r_run_q - 8'd1 : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NQ; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
            r_run_id   <= '0;
            r_run_prio <= '0;
            r_run_q    <= '0;
            r_policy   <= POL_FCFS;
            r_rr_q     <= 8'd4;
            r_top_q    <= 8'd4;
            r_mid_q    <= 8'd8;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POLICY: r_policy <= i_cfg_data[1:0];
                    REG_RR_Q:   r_rr_q   <= i_cfg_data;
                    REG_TOP_Q:  r_top_q  <= i_cfg_data;
                    REG_MID_Q:  r_mid_q  <= i_cfg_data;
                    default:    r_policy <= r_policy;
                endcase
            end
            case (i_cmd)
                C_SIMPLE: begin
                    if (r_action == ACT_TICK && active) begin
                        r_run_q <= tq;
                        if (!r_idle && tq == 8'd0 && r_policy == POL_MLFQ) begin
                            r_run_prio <= r_run_prio - 5'd1;
                        end
                    end
                end
                C_WR_POS, C_APPEND: r_cnt[r_q] <= r_cnt[r_q] + 1'b1;
                C_PREPEND: begin
                    r_head[r_q] <= slot_prev;
                    r_cnt[r_q]  <= r_cnt[r_q] + 1'b1;
                end
                C_RM_END: r_cnt[r_q] <= r_cnt[r_q] - 1'b1;
                C_DISPATCH: begin
                    r_run_id    <= r_rdata.id;
                    r_run_prio  <= r_rdata.prio;
                    r_run_q     <= r_rdata.quantum;
                    r_head[r_q] <= head_next;
                    r_cnt[r_q]  <= r_cnt[r_q] - 1'b1;
                end
                default: r_run_q <= r_run_q;
            endcase
        end
    end

    // per-request working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_LOAD: begin
                r_action <= i_action;
                r_praw   <= i_priority_req;
                r_idle   <= i_cpu_idle;
                r_ent    <= ld_ent;
                r_q      <= ld_q;
                r_dst    <= ld_dst;
                r_mode   <= ld_mode;
                r_k      <= '0;
                r_pos    <= '0;
                r_status <= ST_OK;
                r_yield  <= 1'b0;
                r_sw     <= 1'b0;
            end
            C_SIMPLE: begin
                if (r_action == ACT_TICK) begin
                    r_yield <= active && !r_idle && tq == 8'd0;
                end
                if (r_action == ACT_PREEMPT) begin
                    r_sw <= (r_policy == POL_PRIO || r_policy == POL_MLFQ)
                            && r_run_prio < r_praw;
                end
            end
            C_INC_K, C_WR_K_INC: r_k <= r_k + 1'b1;
            C_WR_K_DEC: r_k <= r_k - 1'b1;
            C_SET_POS: begin
                r_pos <= r_k;
                r_k   <= r_cnt[r_q];
            end
            C_TAKE: r_ent <= r_rdata;
            C_RM_END: r_q <= r_dst;
            C_FIN_EMPTY: r_status <= ST_EMPTY;
            C_FIN_FULL: r_status <= ST_FULL;
            C_PUSH: begin
                r_o_status <= r_status;
                r_o_id     <= r_run_id;
                r_o_prio   <= r_run_prio;
                r_o_q      <= r_run_q;
                r_o_yield  <= r_yield;
                r_o_sw     <= r_sw;
            end
            default: r_k <= r_k;
        endcase
    end

    always_comb begin
        o_st.action    = r_action;
        o_st.mode      = r_mode;
        o_st.full      = (r_cnt[r_q] == DEPTH_C);
        o_st.empty     = (r_cnt[r_q] == '0);
        o_st.k_lt_cnt  = (r_k < r_cnt[r_q]);
        o_st.k_gt_pos  = (r_k > r_pos);
        o_st.k1_lt_cnt = ((CW + 1)'(r_k) + 1'b1) < (CW + 1)'(r_cnt[r_q]);
        o_st.match_id  = (r_rdata.id == r_ent.id);
        o_st.prio_ge   = (r_rdata.prio >= r_ent.prio);
    end

    assign o_status        = r_o_status;
    assign o_out_thread_id = r_o_id;
    assign o_out_priority  = r_o_prio;
    assign o_out_quantum   = r_o_q;
    assign o_yield_now     = r_o_yield;
    assign o_do_switch     = r_o_sw;

endmodule

// ===== rtl/multi_policy_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// multi_policy_thread_scheduler
// Thread scheduler with FCFS, round robin, priority and feedback queue modes.
// ----------------------------------------------------------------------------
// channel   | direction | handshake                   | payload
// requests  | in        | s_axis_tvalid/s_axis_tready | s_axis_tdata (40 bits)
// results   | out       | m_axis_tvalid/m_axis_tready | m_axis_tdata (32 bits)
// config    | in        | i_cfg_we, no wait           | i_cfg_idx, i_cfg_data
//
// tick and preempt check go through the idle, decide and done states; make_ready
// append/prepend does too, and dispatch adds a read state. sorted insert and
// suspend/resume walk the queue memory one entry at a time, with one read then one write per entry moved.
// the queue memory has a single port. a result waits in its own
// register, so the next request is taken while it is still unclaimed.
// synchronous active-low reset empties all queues; no clearing pass.
// ----------------------------------------------------------------------------
module multi_policy_thread_scheduler #(
    parameter int QUEUE_DEPTH = mpts_pkg::QUEUE_DEPTH_DEF,
    parameter int TOP_LEVEL   = mpts_pkg::TOP_LEVEL_DEF,
    parameter int MAX_PRIO    = mpts_pkg::MAX_PRIO_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], thread_id[10:3], priority_req[15:11], quantum_left[23:16],
    // burst_time[31:24], cpu_idle[32], zero fill
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], out_thread_id[9:2], out_priority[14:10], out_quantum[22:15],
    // yield_now[23], do_switch[24], zero fill
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import mpts_pkg::*;

    t_cmd       cmd;
    t_dp_status st;
    logic [1:0] status;
    logic [7:0] out_id, out_q;
    logic [4:0] out_prio;
    logic       yield_now, do_switch;

    mpts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    mpts_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TOP_LEVEL   (TOP_LEVEL),
        .MAX_PRIO    (MAX_PRIO)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_action        (s_axis_tdata[2:0]),
        .i_thread_id     (s_axis_tdata[10:3]),
        .i_priority_req  (s_axis_tdata[15:11]),
        .i_quantum_left  (s_axis_tdata[23:16]),
        .i_burst_time    (s_axis_tdata[31:24]),
        .i_cpu_idle      (s_axis_tdata[32]),
        .o_st            (st),
        .o_status        (status),
        .o_out_thread_id (out_id),
        .o_out_priority  (out_prio),
        .o_out_quantum   (out_q),
        .o_yield_now     (yield_now),
        .o_do_switch     (do_switch)
    );

    assign m_axis_tdata = {7'd0, do_switch, yield_now, out_q, out_prio, out_id, status};

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("status code out of range");

    a_yield_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[23] && m_axis_tdata[24]))
        else $error("yield and switch both set");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

endmodule

// ===== dv/multi_policy_thread_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// multi_policy_thread_scheduler_tb
// Self-checking bench: drives scheduler requests under each policy, predicts
// every result with a behavioral queue model and compares field by field.
// ----------------------------------------------------------------------------
module multi_policy_thread_scheduler_tb;
    import mpts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QD        = 16;
    localparam int TOPL      = 2;
    localparam int MAXP      = 20;
    localparam int NQ        = TOPL + 3;
    localparam int WDOG_MAX  = 20000;
    localparam int LVL_BASE  = 2;

    typedef struct packed {
        logic [7:0] id;
        logic [4:0] prio;
        logic [7:0] quantum;
        logic [7:0] burst;
    } sched_ent_t;

    typedef struct {
        logic [1:0] status;
        logic [7:0] tid;
        logic [4:0] prio;
        logic [7:0] quantum;
        logic       yield_now;
        logic       do_switch;
    } sched_res_t;

    typedef struct {
        logic [2:0] action;
        logic [7:0] tid;
        logic [4:0] prio;
        logic [7:0] qleft;
        logic [7:0] burst;
        logic       idle;
        logic       has_exp;
        logic [1:0] exp_status;
    } req_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;

    multi_policy_thread_scheduler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    sched_ent_t  qmem [NQ][$];
    logic [1:0]  cur_policy;
    logic [7:0]  cur_rr_q, cur_top_q, cur_mid_q;
    logic [7:0]  run_id, run_quantum;
    logic [4:0]  run_prio;

    sched_res_t  pending_results[$];
    logic [1:0]  pending_status_pin[$];
    logic        pending_has_pin[$];
    int          err_count;
    int          wdog;
    int          src_idle_pct;
    int          snk_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic logic [1:0] push_entry(int q, int pos, sched_ent_t e);
        if (qmem[q].size() >= QD) return ST_FULL;
        qmem[q].insert(pos, e);
        return ST_OK;
    endfunction

    function automatic logic [1:0] move_between(int src, int dst, logic [7:0] id);
        sched_ent_t e;
        for (int k = 0; k < qmem[src].size(); k++) begin
            if (qmem[src][k].id == id) begin
                e = qmem[src][k];
                qmem[src].delete(k);
                return push_entry(dst, qmem[dst].size(), e);
            end
        end
        return ST_EMPTY;
    endfunction

    function automatic sched_res_t predict_step(req_row_t r);
        sched_res_t res;
        sched_ent_t e;
        int         p, lvl, q, pos;
        logic       active;
        res = '{default: '0};
        res.status = ST_OK;
        case (r.action)
            ACT_MAKE_READY: begin
                p = (r.prio > MAXP) ? MAXP : r.prio;
                e.id = r.tid; e.quantum = r.qleft; e.burst = r.burst; e.prio = 5'(p);
                case (cur_policy)
                    POL_RR: begin
                        e.quantum = cur_rr_q;
                        res.status = push_entry(READY_Q, qmem[READY_Q].size(), e);
                    end
                    POL_PRIO: begin
                        pos = 0;
                        while (pos < qmem[READY_Q].size() &&
                               qmem[READY_Q][pos].prio >= e.prio) pos++;
                        res.status = push_entry(READY_Q, pos, e);
                    end
                    POL_MLFQ: begin
                        lvl = (p > TOPL) ? TOPL : p;
                        e.prio = 5'(lvl);
                        q = LVL_BASE + lvl;
                        if (e.quantum != 0) begin
                            res.status = push_entry(q, 0, e);
                        end else begin
                            if (lvl == TOPL) e.quantum = cur_top_q;
                            else if (lvl == 0) e.quantum = e.burst;
                            else e.quantum = cur_mid_q;
                            res.status = push_entry(q, qmem[q].size(), e);
                        end
                    end
                    default: res.status = push_entry(READY_Q, qmem[READY_Q].size(), e);
                endcase
            end
            ACT_DISPATCH: begin
                q = READY_Q;
                if (cur_policy == POL_MLFQ) begin
                    q = -1;
                    for (int l = TOPL; l >= 0; l--)
                        if (q < 0 && qmem[LVL_BASE + l].size() != 0) q = LVL_BASE + l;
                end
                if (q < 0 || qmem[q].size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    e = qmem[q].pop_front();
                    run_id = e.id; run_prio = e.prio; run_quantum = e.quantum;
                end
            end
            ACT_TICK: begin
                active = (cur_policy == POL_RR) ||
                         (cur_policy == POL_MLFQ && run_prio >= 1);
                if (active) begin
                    if (run_quantum != 0) run_quantum--;
                    if (!r.idle && run_quantum == 0) begin
                        if (cur_policy == POL_MLFQ) run_prio--;
                        res.yield_now = 1'b1;
                    end
                end
            end
            ACT_PREEMPT:
                res.do_switch = (cur_policy == POL_PRIO || cur_policy == POL_MLFQ) &&
                                (run_prio < r.prio);
            ACT_SUSPEND: res.status = move_between(READY_Q, SUSP_Q, r.tid);
            ACT_RESUME:  res.status = move_between(SUSP_Q, READY_Q, r.tid);
            default: ;
        endcase
        res.tid = run_id; res.prio = run_prio; res.quantum = run_quantum;
        return res;
    endfunction

    task automatic send_request(req_row_t r);
        s_axis_tdata  <= {7'd0, r.idle, r.burst, r.qleft, r.prio, r.tid, r.action};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        pending_results.push_back(predict_step(r));
        pending_has_pin.push_back(r.has_exp);
        pending_status_pin.push_back(r.exp_status);
        // gap after the transaction
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_POLICY: cur_policy = val[1:0];
            REG_RR_Q:   cur_rr_q = val;
            REG_TOP_Q:  cur_top_q = val;
            default:    cur_mid_q = val;
        endcase
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // idle margin before the next phase
        repeat (2 * QD + 10) @(posedge i_clk);
    endtask

    function automatic req_row_t make_row(logic [2:0] a, logic [7:0] t, logic [4:0] p,
                                          logic [7:0] ql, logic [7:0] b, logic idl);
        req_row_t r;
        r = '{action: a, tid: t, prio: p, qleft: ql, burst: b, idle: idl,
              has_exp: 1'b0, exp_status: ST_OK};
        return r;
    endfunction

    function automatic req_row_t random_row();
        req_row_t r;
        int       pick;
        pick = $urandom_range(99);
        r = make_row(3'($urandom_range(5)), 8'($urandom_range(15)),
                     5'($urandom_range(MAXP)), 8'($urandom), 8'($urandom), 1'($urandom));
        if (pick < 30) r.action = ACT_MAKE_READY;
        else if (pick < 50) r.action = ACT_DISPATCH;
        else if (pick < 70) r.action = ACT_TICK;
        else if (pick < 75) r.action = 3'($urandom_range(6, 7));
        else if (pick < 80) begin
            r.tid = 8'($urandom);
            r.prio = 5'($urandom);
        end
        if ($urandom_range(3) == 0) r.qleft = 8'd0;
        if ($urandom_range(9) == 0) r.qleft = 8'd1;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        sched_res_t exp_r;
        logic       pin;
        logic [1:0] pin_st;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                exp_r = pending_results.pop_front();
                pin = pending_has_pin.pop_front();
                pin_st = pending_status_pin.pop_front();
                if (pin && pin_st != exp_r.status)
                    report_mismatch("table status", pin_st, exp_r.status);
                if (m_axis_tdata[1:0] != exp_r.status)
                    report_mismatch("status", m_axis_tdata[1:0], exp_r.status);
                if (m_axis_tdata[9:2] != exp_r.tid)
                    report_mismatch("thread id", m_axis_tdata[9:2], exp_r.tid);
                if (m_axis_tdata[14:10] != exp_r.prio)
                    report_mismatch("priority", m_axis_tdata[14:10], exp_r.prio);
                if (m_axis_tdata[22:15] != exp_r.quantum)
                    report_mismatch("quantum", m_axis_tdata[22:15], exp_r.quantum);
                if (m_axis_tdata[23] != exp_r.yield_now)
                    report_mismatch("yield", m_axis_tdata[23], exp_r.yield_now);
                if (m_axis_tdata[24] != exp_r.do_switch)
                    report_mismatch("switch", m_axis_tdata[24], exp_r.do_switch);
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (!s_axis_tvalid && pending_results.size() == 0))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        req_row_t dir_rows[$];
        logic [1:0] pol_seq[4];
        err_count = 0; wdog = 0;
        src_idle_pct = 28; snk_idle_pct = 88;
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        m_axis_tready = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        cur_policy = POL_FCFS; cur_rr_q = 8'd4; cur_top_q = 8'd4; cur_mid_q = 8'd8;
        run_id = '0; run_prio = '0; run_quantum = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under reset settings (fcfs)
        dir_rows.push_back(make_row(ACT_DISPATCH, 0, 0, 0, 0, 0));
        dir_rows[$].has_exp = 1'b1; dir_rows[$].exp_status = ST_EMPTY;
        dir_rows.push_back(make_row(ACT_SUSPEND, 8'd9, 0, 0, 0, 0));
        dir_rows[$].has_exp = 1'b1; dir_rows[$].exp_status = ST_EMPTY;
        dir_rows.push_back(make_row(ACT_RESUME, 8'd9, 0, 0, 0, 0));
        dir_rows[$].has_exp = 1'b1; dir_rows[$].exp_status = ST_EMPTY;
        for (int i = 0; i < 16; i++) begin
            dir_rows.push_back(make_row(ACT_MAKE_READY, (i == 0) ? 8'hFF : 8'(i),
                               (i == 1) ? 5'h1F : 5'(i), (i == 2) ? 8'hFF : 8'(i),
                               8'hFF, 1'b1));
            dir_rows[$].has_exp = 1'b1; dir_rows[$].exp_status = ST_OK;
        end
        dir_rows.push_back(make_row(ACT_MAKE_READY, 8'd99, 5'd3, 8'd1, 8'd0, 0));
        dir_rows[$].has_exp = 1'b1; dir_rows[$].exp_status = ST_FULL;
        dir_rows.push_back(make_row(ACT_SUSPEND, 8'd5, 0, 0, 0, 0));
        dir_rows.push_back(make_row(ACT_RESUME, 8'd5, 0, 0, 0, 0));
        dir_rows.push_back(make_row(ACT_DISPATCH, 0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(ACT_TICK, 0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(ACT_PREEMPT, 0, 5'h1F, 0, 0, 0));
        dir_rows.push_back(make_row(3'd7, 0, 0, 0, 0, 0));
        foreach (dir_rows[i]) send_request(dir_rows[i]);
        drain_results();

        // random phases over policies and register extremes
        pol_seq = '{POL_RR, POL_PRIO, POL_MLFQ, POL_FCFS};
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin src_idle_pct = 88; snk_idle_pct = 28; end
            if (ph == 8) begin src_idle_pct = 0; snk_idle_pct = 0; end
            write_reg(REG_POLICY, 8'(pol_seq[ph % 4]));
            write_reg(REG_RR_Q,  (ph % 3 == 0) ? 8'd1 : (ph % 3 == 1) ? 8'd255 : 8'($urandom));
            write_reg(REG_TOP_Q, (ph % 3 == 1) ? 8'd1 : (ph % 3 == 2) ? 8'd255 : 8'd2);
            write_reg(REG_MID_Q, (ph % 3 == 2) ? 8'd1 : (ph % 3 == 0) ? 8'd255 : 8'd3);
            if (ph == 11) write_reg(REG_POLICY, 8'(POL_MLFQ));
            for (int n = 0; n < 55; n++) send_request(random_row());
            drain_results();
        end

        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== multi_policy_thread_scheduler.f =====
rtl/mpts_pkg.sv
rtl/mpts_ctrl.sv
rtl/mpts_dp.sv
rtl/multi_policy_thread_scheduler.sv
dv/multi_policy_thread_scheduler_tb.sv
